@@ rtl/gpst_pkg.sv @@
// gpst_pkg: widths, register indexes and stream layout of the gated pulse stimulus timer
// self-contained, no dependencies
// used by the core, its port checker, the drive checker and tb_top
package gpst_pkg;

    localparam int TIME_W     = 32;
    localparam int FREQ_W     = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // stream layout, fields packed from bit 0 and padded to whole bytes
    localparam int S_TDATA_W  = 72;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = 72;

    localparam int S_NOW_LSB  = 0;
    localparam int S_REND_LSB = 32;
    localparam int S_RUN_BIT  = 64;

    localparam int M_ON_BIT    = 0;
    localparam int M_ACT_BIT   = 1;
    localparam int M_END_BIT   = 2;
    localparam int M_START_LSB = 3;
    localparam int M_STOP_LSB  = 35;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ARMED    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DURATION = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET   = 3'd4;

    // stimulus modes
    localparam logic MODE_CYCLE  = 1'b0;
    localparam logic MODE_REWARD = 1'b1;

    // item kinds on s_tuser
    localparam logic ACT_TICK    = 1'b0;
    localparam logic ACT_TRIGGER = 1'b1;

    localparam logic [TIME_W-1:0] DURATION_RST = 32'd1000;
    localparam logic [FREQ_W-1:0] FREQ_RST     = 10'd20;

endpackage

@@ rtl/gated_pulse_stimulus_timer_core.sv @@
// gated_pulse_stimulus_timer_core: stimulus drive timer with a bit-serial half-period divider
// depends on gpst_pkg for widths, register indexes and stream layout
//
// usage
//   s_* carries one item per millisecond tick or reward trigger: s_tuser is the
//   kind (tick or trigger), s_tdata the time stamp, the reward end stamp and
//   the run flag. m_* returns exactly one result item per input item: drive
//   level, period state, an end flag and the ended stimulus start and end
//   relative to the session offset.
//   cfg_we/cfg_index/cfg_data write the five settings registers, only while idle.
// processing
//   the half-period duration_ms / frequency_hz / 2 is worked out for every item
//   by a restoring 32-step divider that yields one quotient bit per cycle.
//   after it come the period decision, the pulse decision and the report
//   stage. a new item is taken only in idle, once the result of the last one
//   has left the report stage for the output register.
// reset
//   rst_n clears all state: period inactive, drive off, time stamps zero,
//   settings back to disarmed, cycle mode, 1000 ms, 20 Hz, offset zero.
// back-pressure
//   the result sits in an output register; the block takes the next item while
//   it waits. a second result waits in the report stage until m_tready frees
//   the register, and no further item is taken meanwhile.
module gated_pulse_stimulus_timer_core
    import gpst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // now_ms[31:0], reward_end_ms[63:32], run_enable[64], zero pad
    input  logic [S_TUSER_W-1:0]  s_tuser,   // action[0]
    // result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // output_on[0], stim_active[1], stim_ended[2],
                                             // stim_start_rel[34:3], stim_end_rel[66:35], zero pad
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PERIOD,
        ST_PULSE,
        ST_REPORT
    } state_t;

    localparam int CNT_W = $clog2(TIME_W);

    state_t              state_reg,    state_next;
    // settings
    logic                armed_reg,    armed_next;
    logic                mode_reg,     mode_next;
    logic [TIME_W-1:0]   dur_reg,      dur_next;
    logic [FREQ_W-1:0]   freq_reg,     freq_next;
    logic [TIME_W-1:0]   offset_reg,   offset_next;
    // timer state
    logic                active_reg,   active_next;
    logic                drive_reg,    drive_next;
    logic [TIME_W-1:0]   lpt_reg,      lpt_next;     // last period toggle
    logic [TIME_W-1:0]   lht_reg,      lht_next;     // last half-period toggle
    logic [TIME_W-1:0]   start_reg,    start_next;
    logic [TIME_W-1:0]   rew_end_reg,  rew_end_next;
    // captured item
    logic                act_reg,      act_next;
    logic [TIME_W-1:0]   now_reg,      now_next;
    logic [TIME_W-1:0]   rend_reg,     rend_next;
    logic                run_reg,      run_next;
    // divider: dividend shifts out at the top, quotient bits shift in at the bottom
    logic [TIME_W-1:0]   quo_reg,      quo_next;
    logic [FREQ_W-1:0]   rem_reg,      rem_next;
    logic [CNT_W-1:0]    cnt_reg,      cnt_next;
    // per-item results
    logic                ended_reg,    ended_next;
    logic [TIME_W-1:0]   start_rel_reg, start_rel_next;
    logic                out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;

    logic                in_take;
    logic                go;
    logic [FREQ_W-1:0]   divisor;
    logic [FREQ_W:0]     rem_shift;
    logic                rem_ge;
    logic [FREQ_W:0]     rem_diff;
    logic [TIME_W-1:0]   half;
    logic [TIME_W-1:0]   since;
    logic [TIME_W-1:0]   rend_eff;
    logic                active_eff;
    logic [TIME_W-1:0]   end_rel;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_take  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign go = armed_reg && run_reg;

    // zero frequency counts as one
    assign divisor   = (freq_reg == '0) ? FREQ_W'(1) : freq_reg;
    assign rem_shift = {rem_reg, quo_reg[TIME_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, divisor});
    assign rem_diff  = rem_shift - {1'b0, divisor};
    // quotient by two
    assign half      = {1'b0, quo_reg[TIME_W-1:1]};

    assign rend_eff   = act_reg ? rend_reg : rew_end_reg;
    assign active_eff = act_reg || active_reg;

    always_comb
    begin
        state_next     = state_reg;
        armed_next     = armed_reg;
        mode_next      = mode_reg;
        dur_next       = dur_reg;
        freq_next      = freq_reg;
        offset_next    = offset_reg;
        active_next    = active_reg;
        drive_next     = drive_reg;
        lpt_next       = lpt_reg;
        lht_next       = lht_reg;
        start_next     = start_reg;
        rew_end_next   = rew_end_reg;
        act_next       = act_reg;
        now_next       = now_reg;
        rend_next      = rend_reg;
        run_next       = run_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        ended_next     = ended_reg;
        start_rel_next = start_rel_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        since          = now_reg - lpt_reg;
        end_rel        = now_reg - offset_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_ARMED:    armed_next  = cfg_data[0];
                REG_MODE:     mode_next   = cfg_data[0];
                REG_DURATION: dur_next    = cfg_data[TIME_W-1:0];
                REG_FREQ:     freq_next   = cfg_data[FREQ_W-1:0];
                REG_OFFSET:   offset_next = cfg_data[TIME_W-1:0];
                default:      ;
            endcase
        end

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    act_next   = s_tuser[0];
                    now_next   = s_tdata[S_NOW_LSB +: TIME_W];
                    rend_next  = s_tdata[S_REND_LSB +: TIME_W];
                    run_next   = s_tdata[S_RUN_BIT];
                    quo_next   = dur_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    ended_next = 1'b0;
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                quo_next = {quo_reg[TIME_W-2:0], rem_ge};
                rem_next = rem_ge ? rem_diff[FREQ_W-1:0] : rem_shift[FREQ_W-1:0];
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(TIME_W - 1))
                begin
                    state_next = ST_PERIOD;
                end
            end

            ST_PERIOD:
            begin
                if (go && mode_reg == MODE_CYCLE)
                begin
                    since = now_reg - lpt_reg;
                    if (since >= dur_reg)
                    begin
                        lpt_next = now_reg;
                        if (active_reg)
                        begin
                            active_next = 1'b0;
                            ended_next  = 1'b1;
                        end
                        else
                        begin
                            active_next = 1'b1;
                            start_next  = now_reg;
                        end
                    end
                end
                else if (go)
                begin
                    // a trigger latches the end stamp and may extend a running stimulus
                    if (act_reg == ACT_TRIGGER)
                    begin
                        rew_end_next = rend_reg;
                    end
                    active_next = active_eff;
                    if (active_eff)
                    begin
                        if (now_reg <= rend_eff)
                        begin
                            if (!drive_reg)
                            begin
                                start_next = now_reg;
                                drive_next = 1'b1;
                            end
                        end
                        else
                        begin
                            active_next = 1'b0;
                            ended_next  = 1'b1;
                        end
                    end
                    else
                    begin
                        drive_next = 1'b0;
                    end
                end
                state_next = ST_PULSE;
            end

            ST_PULSE:
            begin
                if (go && mode_reg == MODE_CYCLE)
                begin
                    if (active_reg)
                    begin
                        since = now_reg - lht_reg;
                        if (since >= half)
                        begin
                            lht_next   = now_reg;
                            drive_next = !drive_reg;
                        end
                    end
                    else
                    begin
                        drive_next = 1'b0;
                    end
                end
                start_rel_next = start_reg - offset_reg;
                state_next     = ST_REPORT;
            end

            ST_REPORT:
            begin
                // wait here while the previous result is still unclaimed
                if (!out_valid_reg || m_tready)
                begin
                    out_data_next = '0;
                    out_data_next[M_ON_BIT]  = drive_reg;
                    out_data_next[M_ACT_BIT] = active_reg;
                    out_data_next[M_END_BIT] = ended_reg;
                    if (ended_reg)
                    begin
                        out_data_next[M_START_LSB +: TIME_W] = start_rel_reg;
                        out_data_next[M_STOP_LSB +: TIME_W]  = end_rel;
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            armed_reg     <= 1'b0;
            mode_reg      <= MODE_CYCLE;
            dur_reg       <= DURATION_RST;
            freq_reg      <= FREQ_RST;
            offset_reg    <= '0;
            active_reg    <= 1'b0;
            drive_reg     <= 1'b0;
            lpt_reg       <= '0;
            lht_reg       <= '0;
            start_reg     <= '0;
            rew_end_reg   <= '0;
            act_reg       <= 1'b0;
            now_reg       <= '0;
            rend_reg      <= '0;
            run_reg       <= 1'b0;
            quo_reg       <= '0;
            rem_reg       <= '0;
            cnt_reg       <= '0;
            ended_reg     <= 1'b0;
            start_rel_reg <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            armed_reg     <= armed_next;
            mode_reg      <= mode_next;
            dur_reg       <= dur_next;
            freq_reg      <= freq_next;
            offset_reg    <= offset_next;
            active_reg    <= active_next;
            drive_reg     <= drive_next;
            lpt_reg       <= lpt_next;
            lht_reg       <= lht_next;
            start_reg     <= start_next;
            rew_end_reg   <= rew_end_next;
            act_reg       <= act_next;
            now_reg       <= now_next;
            rend_reg      <= rend_next;
            run_reg       <= run_next;
            quo_reg       <= quo_next;
            rem_reg       <= rem_next;
            cnt_reg       <= cnt_next;
            ended_reg     <= ended_next;
            start_rel_reg <= start_rel_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

endmodule

@@ rtl/gpst_checker.sv @@
// gpst_checker: port-level assertions for gated_pulse_stimulus_timer_core
// depends on gpst_pkg for the stream layout; bound to the core below
module gpst_checker
    import gpst_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // a stalled result item holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("gpst: stalled result changed");

    // an ended stimulus always leaves the period inactive
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[M_END_BIT] |-> !m_tdata[M_ACT_BIT])
        else $error("gpst: ended item reports active period");

    // relative stamps are zero unless a stimulus ended
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[M_END_BIT] |->
            m_tdata[M_START_LSB +: TIME_W] == '0 && m_tdata[M_STOP_LSB +: TIME_W] == '0)
        else $error("gpst: stamps set without an ended stimulus");

    // a taken item blocks input and cannot produce its result at once
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready && !$rose(m_tvalid))
        else $error("gpst: item overlap or result too early");

endmodule

bind gated_pulse_stimulus_timer_core gpst_checker u_gpst_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ dv/gpst_drive_checker.sv @@
// gpst_drive_checker: watches the settings port and both item streams of the stimulus timer,
// predicts every result item from its own copy of the timer state and compares field by field
// depends on gpst_pkg for widths, register indexes and stream layout
module gpst_drive_checker
    import gpst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // now_ms[31:0], reward_end_ms[63:32], run_enable[64]
    input  logic [S_TUSER_W-1:0]  s_tuser,   // action[0]
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,   // output_on[0], stim_active[1], stim_ended[2],
                                             // stim_start_rel[34:3], stim_end_rel[66:35]
    output int                    fail_count,
    output int                    pending
);

    typedef struct packed {
        logic              output_on;
        logic              stim_active;
        logic              stim_ended;
        logic [TIME_W-1:0] start_rel;
        logic [TIME_W-1:0] end_rel;
    } drive_report_t;

    drive_report_t reports_due[$];

    // settings mirror
    logic              armed_q;
    logic              mode_q;
    logic [TIME_W-1:0] duration_q;
    logic [FREQ_W-1:0] freq_q;
    logic [TIME_W-1:0] offset_q;

    // timer state
    logic              active_q;
    logic              level_q;
    logic [TIME_W-1:0] period_mark;
    logic [TIME_W-1:0] half_mark;
    logic [TIME_W-1:0] start_mark;
    logic [TIME_W-1:0] reward_mark;

    task automatic flag_mismatch(input string what, input logic [TIME_W-1:0] got,
                                 input logic [TIME_W-1:0] want);
        fail_count++;
        $display("drive check: %s got %h want %h at %0t", what, got, want, $time);
    endtask

    task automatic advance_timer(input logic act, input logic [TIME_W-1:0] now,
                                 input logic [TIME_W-1:0] rend, input logic run,
                                 output drive_report_t rep);
        logic              ended;
        logic [TIME_W-1:0] stop;
        logic [TIME_W-1:0] gap;
        logic [TIME_W-1:0] half;
        logic [FREQ_W-1:0] divisor;
        ended = 1'b0;
        stop  = '0;
        if (armed_q && run) begin
            if (mode_q == MODE_CYCLE) begin
                gap = now - period_mark;
                if (gap >= duration_q) begin
                    period_mark = now;
                    if (active_q) begin
                        active_q = 1'b0;
                        ended    = 1'b1;
                        stop     = now;
                    end
                    else begin
                        active_q   = 1'b1;
                        start_mark = now;
                    end
                end
                // zero divisor counts as one
                divisor = (freq_q == '0) ? FREQ_W'(1) : freq_q;
                half    = duration_q / {{(TIME_W-FREQ_W){1'b0}}, divisor} / 32'd2;
                if (active_q) begin
                    gap = now - half_mark;
                    if (gap >= half) begin
                        half_mark = now;
                        level_q   = ~level_q;
                    end
                end
                else
                    level_q = 1'b0;
            end
            else begin
                if (act == ACT_TRIGGER) begin
                    active_q    = 1'b1;
                    reward_mark = rend;
                end
                if (active_q) begin
                    if (now <= reward_mark) begin
                        if (!level_q) begin
                            start_mark = now;
                            level_q    = 1'b1;
                        end
                    end
                    else begin
                        active_q = 1'b0;
                        ended    = 1'b1;
                        stop     = now;
                    end
                end
                else
                    level_q = 1'b0;
            end
        end
        rep.output_on   = level_q;
        rep.stim_active = active_q;
        rep.stim_ended  = ended;
        rep.start_rel   = ended ? start_mark - offset_q : '0;
        rep.end_rel     = ended ? stop - offset_q : '0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        drive_report_t due;
        drive_report_t fresh;
        if (!rst_n)
        begin
            armed_q     = 1'b0;
            mode_q      = MODE_CYCLE;
            duration_q  = DURATION_RST;
            freq_q      = FREQ_RST;
            offset_q    = '0;
            active_q    = 1'b0;
            level_q     = 1'b0;
            period_mark = '0;
            half_mark   = '0;
            start_mark  = '0;
            reward_mark = '0;
            fail_count  = 0;
            reports_due.delete();
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (reports_due.size() == 0)
                    flag_mismatch("result item with nothing awaited", m_tdata[TIME_W-1:0], '0);
                else
                begin
                    due = reports_due.pop_front();
                    if (m_tdata[M_ON_BIT] !== due.output_on)
                        flag_mismatch("output_on", TIME_W'(m_tdata[M_ON_BIT]),
                                      TIME_W'(due.output_on));
                    if (m_tdata[M_ACT_BIT] !== due.stim_active)
                        flag_mismatch("stim_active", TIME_W'(m_tdata[M_ACT_BIT]),
                                      TIME_W'(due.stim_active));
                    if (m_tdata[M_END_BIT] !== due.stim_ended)
                        flag_mismatch("stim_ended", TIME_W'(m_tdata[M_END_BIT]),
                                      TIME_W'(due.stim_ended));
                    if (m_tdata[M_START_LSB +: TIME_W] !== due.start_rel)
                        flag_mismatch("stim_start_rel", m_tdata[M_START_LSB +: TIME_W],
                                      due.start_rel);
                    if (m_tdata[M_STOP_LSB +: TIME_W] !== due.end_rel)
                        flag_mismatch("stim_end_rel", m_tdata[M_STOP_LSB +: TIME_W], due.end_rel);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ARMED:    armed_q    = cfg_data[0];
                    REG_MODE:     mode_q     = cfg_data[0];
                    REG_DURATION: duration_q = cfg_data[TIME_W-1:0];
                    REG_FREQ:     freq_q     = cfg_data[FREQ_W-1:0];
                    REG_OFFSET:   offset_q   = cfg_data[TIME_W-1:0];
                    default:      ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                advance_timer(s_tuser[0], s_tdata[S_NOW_LSB +: TIME_W],
                              s_tdata[S_REND_LSB +: TIME_W], s_tdata[S_RUN_BIT], fresh);
                reports_due.push_back(fresh);
            end
            pending <= reports_due.size();
        end
    end

endmodule

@@ dv/tb_top.sv @@
// tb_top: stimulus and verdict for the gated pulse stimulus timer core
// drives settings and time-stamp items, idles both stream sides at random and leaves
// prediction and comparison to gpst_drive_checker; depends on gpst_pkg
module tb_top;
    import gpst_pkg::*;

    // receiver hold-off, long enough for the core to fill and stall its input
    localparam int HOLD_OFF_CYCLES = 3000;
    // cycles with no item accepted on either side before the run is called hung
    localparam int QUIET_LIMIT     = 20000;
    // settle time after the last drain, covering anything still in flight
    localparam int SETTLE_CYCLES   = 50;
    localparam int PHASE_ITEMS     = 115;
    localparam int PHASE_COUNT     = 13;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // now_ms[31:0], reward_end_ms[63:32], run_enable[64], zero pad
    logic [S_TUSER_W-1:0]  s_tuser;   // action[0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // output_on[0], stim_active[1], stim_ended[2],
                                      // stim_start_rel[34:3], stim_end_rel[66:35], zero pad

    int fail_count;
    int pending;

    // idling knobs (percent per cycle) and the hold-off and watchdog counters
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_cycles    = 0;
    int quiet_cycles   = 0;

    // stimulus-side view of time and of the current settings
    logic [TIME_W-1:0] clock_ms;
    logic [TIME_W-1:0] cur_duration;
    logic              cur_mode;

    gated_pulse_stimulus_timer_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    gpst_drive_checker drive_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver: a pending hold-off wins, otherwise random stalls at the phase rate
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog on progress, not on total run length
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // offer one item, with random idle cycles in front, and return once it is taken;
    // tvalid is only lowered when an idle cycle actually follows
    task automatic send_item(input logic act, input logic [TIME_W-1:0] now,
                             input logic [TIME_W-1:0] rend, input logic run);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(S_TDATA_W-S_RUN_BIT-1){1'b0}}, run, rend, now};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // stop offering and wait until every awaited result has come back;
    // the first edge lets the checker count the item just taken
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // writes all five registers back to back; only called with the core idle
    task automatic apply_settings(input logic arm, input logic mode,
                                  input logic [TIME_W-1:0] dur, input logic [FREQ_W-1:0] freq,
                                  input logic [TIME_W-1:0] off);
        write_reg(REG_ARMED,    {31'b0, arm});
        write_reg(REG_MODE,     {31'b0, mode});
        write_reg(REG_DURATION, dur);
        write_reg(REG_FREQ,     {22'b0, freq});
        write_reg(REG_OFFSET,   off);
        cfg_we       <= 1'b0;
        cur_mode     = mode;
        cur_duration = dur;
    endtask

    // random items: mostly a slowly running clock so periods and pulses really turn over,
    // now and then a jump anywhere or close to the wrap point
    task automatic run_phase(input int count);
        int                roll;
        logic              act;
        logic              run;
        logic [TIME_W-1:0] rend;
        for (int k = 0; k < count; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
                clock_ms = $urandom;
            else if (roll < 5)
                clock_ms = 32'hFFFF_FFF0 + $urandom_range(0, 8);
            else
                clock_ms = clock_ms + $urandom_range(0, 3);
            run  = ($urandom_range(0, 99) >= 5);
            rend = $urandom;
            act  = ACT_TICK;
            if (cur_mode == MODE_REWARD)
            begin
                if ($urandom_range(0, 99) < 12)
                begin
                    act  = ACT_TRIGGER;
                    roll = $urandom_range(0, 99);
                    // mostly a short reward window ahead, some already over, some anywhere
                    if (roll < 70)
                        rend = clock_ms + $urandom_range(0, 40);
                    else if (roll < 85)
                        rend = clock_ms - $urandom_range(1, 5);
                end
            end
            else
                act = 1'($urandom_range(0, 1));   // ignored in cycle mode
            send_item(act, clock_ms, rend, run);
        end
    endtask

    initial
    begin
        logic              arm;
        logic [TIME_W-1:0] dur;
        logic [FREQ_W-1:0] freq;
        logic [TIME_W-1:0] off;
        int                items;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        clock_ms     = '0;
        cur_mode     = MODE_CYCLE;
        cur_duration = DURATION_RST;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // reset settings are disarmed, so even a trigger changes nothing
        send_item(ACT_TRIGGER, 32'd5, 32'd100, 1'b1);
        drain();

        // widest duration and divisor: a period only turns over at a gap of all ones,
        // and the reported times wrap below the largest offset
        apply_settings(1'b1, MODE_CYCLE, 32'hFFFF_FFFF, 10'h3FF, 32'hFFFF_FFFF);
        send_item(ACT_TICK,    32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
        send_item(ACT_TRIGGER, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1);
        send_item(ACT_TICK,    32'h0000_0000, 32'h0000_0000, 1'b0);   // program not running
        drain();

        // zero duration and zero divisor: every item flips the period and the drive
        apply_settings(1'b1, MODE_CYCLE, 32'd0, 10'd0, 32'd0);
        for (int k = 0; k < 4; k++)
            send_item(ACT_TICK, k / 2, 32'd0, 1'b1);
        drain();

        // one-millisecond periods, zero half cycle
        apply_settings(1'b1, MODE_CYCLE, 32'd1, 10'd1, 32'h8000_0000);
        send_item(ACT_TICK, 32'd10, 32'd0, 1'b1);
        send_item(ACT_TICK, 32'd11, 32'd0, 1'b1);
        send_item(ACT_TICK, 32'd11, 32'd0, 1'b1);
        drain();

        // reward mode: window, extension without a new start, end at the last stamp,
        // drive cleared on the following item, a window already over, a gated trigger
        apply_settings(1'b1, MODE_REWARD, DURATION_RST, FREQ_RST, 32'd100);
        send_item(ACT_TICK,    32'd150,       32'd0,         1'b1);
        send_item(ACT_TRIGGER, 32'd200,       32'd210,       1'b1);
        send_item(ACT_TICK,    32'd205,       32'd0,         1'b1);
        send_item(ACT_TRIGGER, 32'd207,       32'hFFFF_FFFF, 1'b1);
        send_item(ACT_TICK,    32'hFFFF_FFFF, 32'd0,         1'b1);
        send_item(ACT_TRIGGER, 32'd0,         32'd0,         1'b1);
        send_item(ACT_TICK,    32'd1,         32'd0,         1'b1);
        send_item(ACT_TICK,    32'd2,         32'd0,         1'b1);
        send_item(ACT_TRIGGER, 32'd50,        32'd10,        1'b1);
        send_item(ACT_TRIGGER, 32'd60,        32'd100,       1'b0);
        drain();

        apply_settings(1'b0, MODE_REWARD, DURATION_RST, FREQ_RST, 32'd0);
        send_item(ACT_TRIGGER, 32'd70, 32'd90, 1'b1);
        drain();

        // ---- random part ----
        // even phases run cycle mode, odd ones reward mode; special settings on the
        // even ones where the period logic is most exposed
        clock_ms = $urandom_range(0, 1000);
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            arm   = 1'b1;
            dur   = $urandom_range(1, 40);
            freq  = FREQ_W'($urandom_range(1, 6));
            off   = $urandom;
            items = PHASE_ITEMS;
            case (p)
                2:  begin dur = 32'd0; off = 32'd0; end
                4:  freq = 10'd0;
                6:  begin arm = 1'b0; items = 40; end
                8:  begin dur = 32'hFFFF_FFFF; freq = 10'h3FF; end
                10: begin dur = $urandom; freq = FREQ_W'($urandom_range(0, 1023));
                          off = 32'hFFFF_FFFF; end
                12: begin dur = 32'd1; freq = 10'h3FF; end
                default: ;
            endcase
            apply_settings(arm, p[0], dur, freq, off);

            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase

            // long receiver hold-off while items keep coming, so the core backs up
            if (p == 4)
                hold_cycles = HOLD_OFF_CYCLES;

            if (p == 8)
            begin
                // sender pause half way until the core has emptied
                run_phase(items / 2);
                drain();
                run_phase(items - items / 2);
            end
            else
                run_phase(items);
            drain();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
